// ----- rtl/servo_sweep_scan_buffer_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the checker of the sweep scanner.
// ---------------------------------------------------------------------------
`ifndef SERVO_SWEEP_SCAN_BUFFER_ASSERT_SVH
`define SERVO_SWEEP_SCAN_BUFFER_ASSERT_SVH

// Property checked on every rising edge, switched off while reset is high.
`define SSB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SSB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/ssb_pkg.sv -----
// ---------------------------------------------------------------------------
// ssb_pkg
// Shared codes, reset values and types of the servo sweep scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package ssb_pkg;

   // Store depth and result limits.
   localparam int STORE_DEPTH_DEFAULT = 32;
   localparam int MAX_RESULTS         = 34;
   localparam int MAX_POINTS          = MAX_RESULTS - 1;
   localparam int POINT_W             = 24;

   // Register reset values.
   localparam logic [4:0] STEP_SIZE_RESET  = 5'd5;
   localparam logic [7:0] LOW_LIMIT_RESET  = 8'd15;
   localparam logic [7:0] HIGH_LIMIT_RESET = 8'd165;
   localparam logic [7:0] ANGLE_RESET      = 8'd90;

   // Register indexes.
   localparam logic [1:0] REG_STEP_SIZE  = 2'd0;
   localparam logic [1:0] REG_LOW_LIMIT  = 2'd1;
   localparam logic [1:0] REG_HIGH_LIMIT = 2'd2;

   // Input item kinds.
   localparam logic [2:0] KIND_TICK       = 3'd0;
   localparam logic [2:0] KIND_POWER_ON   = 3'd1;
   localparam logic [2:0] KIND_POWER_OFF  = 3'd2;
   localparam logic [2:0] KIND_MANUAL_ON  = 3'd3;
   localparam logic [2:0] KIND_MANUAL_OFF = 3'd4;
   localparam logic [2:0] KIND_SET_ANGLE  = 3'd5;

   // Result kinds.
   localparam logic [2:0] RES_MOVE    = 3'd0;
   localparam logic [2:0] RES_POINT   = 3'd1;
   localparam logic [2:0] RES_MANUAL  = 3'd2;
   localparam logic [2:0] RES_ONLINE  = 3'd3;
   localparam logic [2:0] RES_STANDBY = 3'd4;

   // Control of the point chain: load one cell, or shift all towards the head.
   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/ssb_cell.sv -----
// ---------------------------------------------------------------------------
// ssb_cell
// One cell of the point chain: takes its neighbour's point when the chain
// shifts, otherwise loads a new point when addressed.
// ---------------------------------------------------------------------------
`default_nettype none

module ssb_cell
   import ssb_pkg::*;
#(
   parameter int CellIndex = 0,
   parameter int IndexW    = 5
) (
   input  wire logic                clock,
   input  wire chain_ctrl_type      ctrl,
   input  wire logic [IndexW-1:0]   wr_index,
   input  wire logic [POINT_W-1:0]  wr_data,
   input  wire logic [POINT_W-1:0]  next_data,
   output logic      [POINT_W-1:0]  data_q
);

   logic [POINT_W-1:0] data_ff;
   logic [POINT_W-1:0] data_in;
   logic               selected;

   // The cell answers only to its own index.
   assign selected = ctrl.load && (wr_index == IndexW'(CellIndex));

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = next_data;
      end else if (selected) begin
         data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

`default_nettype wire

// ----- rtl/ssb_point_chain.sv -----
// ---------------------------------------------------------------------------
// ssb_point_chain
// Row of point cells. Points are written at the fill position and leave,
// oldest first, from the head cell as the row shifts.
// ---------------------------------------------------------------------------
`default_nettype none

module ssb_point_chain
   import ssb_pkg::*;
#(
   parameter int StoreDepth = STORE_DEPTH_DEFAULT,
   localparam int IndexW    = $clog2(StoreDepth)
) (
   input  wire logic                clock,
   input  wire chain_ctrl_type      ctrl,
   input  wire logic [IndexW-1:0]   wr_index,
   input  wire logic [POINT_W-1:0]  wr_data,
   output logic      [POINT_W-1:0]  head_data
);

   logic [POINT_W-1:0] cell_data [StoreDepth];
   logic [POINT_W-1:0] cell_next [StoreDepth];

   // Each cell sees its upper neighbour; the last one shifts in zero.
   for (genvar i = 0; i < StoreDepth; i++) begin : g_cell
      if (i == StoreDepth - 1) begin : g_end
         assign cell_next[i] = '0;
      end else begin : g_mid
         assign cell_next[i] = cell_data[i+1];
      end

      ssb_cell #(
         .CellIndex (i),
         .IndexW    (IndexW)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .wr_index  (wr_index),
         .wr_data   (wr_data),
         .next_data (cell_next[i]),
         .data_q    (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule

`default_nettype wire

// ----- rtl/servo_sweep_scan_buffer.sv -----
// ---------------------------------------------------------------------------
// servo_sweep_scan_buffer
// Bouncing servo sweep scanner with a chained point store.
// ---------------------------------------------------------------------------
// Items arrive on the req_ channel (kind, distance, target angle) and results
// leave on the rsp_ channel through a single output register; rsp_last marks
// the final result of an item. The csr_ port writes step size and the two
// limits and is always ready; it must be written only while the block is idle,
// which the block does not enforce. An item is accepted in the idle state
// whenever the output register is free or being emptied in the same cycle.
// Its first result is registered on acceptance; that of a draining tick is
// the oldest point, loaded in the drain state. Items with at most one result
// are handled without leaving the idle state. Power on gives a move, then an
// online result. A tick that reaches a limit drains min(points, 33) points
// from the head cell of the chain, one a cycle unless stalled, then the move.
// The drain rate is set by the single head cell that feeds the output
// register. When the receiver stalls, the output register holds its result
// and the drain pauses; no item is accepted meanwhile. Reset empties the
// output register, clears the state machine, the point count, the mode flags
// and loads angle 90 with an upward sweep and register reset values. The
// point cells need no clearing: only filled cells are read.
// ---------------------------------------------------------------------------
`default_nettype none

module servo_sweep_scan_buffer
   import ssb_pkg::*;
#(
   parameter int StoreDepth = STORE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [15:0] req_distance,
   input  wire logic [7:0]  req_target_angle,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [2:0]  rsp_result_kind,
   output logic      [7:0]  rsp_angle_out,
   output logic      [15:0] rsp_distance_out,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   localparam int IndexW = $clog2(StoreDepth);
   localparam int CountW = $clog2(StoreDepth + 1);
   localparam int DrainW = $clog2(MAX_RESULTS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DRAIN  = 4'b0010,
      ST_MOVE   = 4'b0100,
      ST_ONLINE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic [7:0]         low_ff, low_in;
   logic [7:0]         high_ff, high_in;
   logic [7:0]         angle_ff, angle_in;
   logic               dir_ff, dir_in;
   logic               enabled_ff, enabled_in;
   logic               manual_ff, manual_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic [DrainW-1:0]  drain_ff, drain_in;

   logic               out_valid_ff, out_valid_in;
   logic [2:0]         out_kind_ff, out_kind_in;
   logic [7:0]         out_angle_ff, out_angle_in;
   logic [15:0]        out_dist_ff, out_dist_in;
   logic               out_last_ff, out_last_in;

   chain_ctrl_type     chain_ctrl;
   logic [IndexW-1:0]  chain_index;
   logic [POINT_W-1:0] chain_wr_data;
   logic [POINT_W-1:0] chain_head;

   logic               out_free;
   logic               req_take;
   logic               store_ok;
   logic signed [9:0]  next_angle;
   logic [CountW-1:0]  count_after;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Tick arithmetic: next angle and fill position.
   assign store_ok    = (count_ff < CountW'(StoreDepth));
   assign count_after = count_ff + CountW'(store_ok);
   assign next_angle  = dir_ff ? (signed'({2'b00, angle_ff}) + signed'({5'b00000, step_ff}))
                               : (signed'({2'b00, angle_ff}) - signed'({5'b00000, step_ff}));
   assign chain_index   = count_ff[IndexW-1:0];
   assign chain_wr_data = {angle_ff, req_distance};

   // Configuration writes.
   always_comb begin
      step_in = step_ff;
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_STEP_SIZE:  step_in = csr_data[4:0];
            REG_LOW_LIMIT:  low_in  = csr_data;
            REG_HIGH_LIMIT: high_in = csr_data;
            default:        ;
         endcase
      end
   end

   // Sequencer: item handling, drain and trailing results.
   always_comb begin
      state_in     = state_ff;
      angle_in     = angle_ff;
      dir_in       = dir_ff;
      enabled_in   = enabled_ff;
      manual_in    = manual_ff;
      count_in     = count_ff;
      drain_in     = drain_ff;
      chain_ctrl   = '0;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_angle_in = out_angle_ff;
      out_dist_in  = out_dist_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_kind)
                  KIND_TICK: begin
                     if (enabled_ff && !manual_ff) begin
                        chain_ctrl.load = store_ok;
                        count_in        = count_after;
                        out_valid_in    = 1'b1;
                        out_kind_in     = RES_MOVE;
                        out_dist_in     = '0;
                        out_last_in     = 1'b1;
                        if (next_angle >= signed'({2'b00, high_ff})) begin
                           angle_in = high_ff;
                           dir_in   = 1'b0;
                        end else if (next_angle <= signed'({2'b00, low_ff})) begin
                           angle_in = low_ff;
                           dir_in   = 1'b1;
                        end else begin
                           angle_in = next_angle[7:0];
                        end
                        out_angle_in = angle_in;
                        // A turn point drains the store before the move.
                        if ((next_angle >= signed'({2'b00, high_ff})) ||
                            (next_angle <= signed'({2'b00, low_ff}))) begin
                           count_in = '0;
                           if (int'(count_after) > MAX_POINTS) begin
                              drain_in = DrainW'(MAX_POINTS);
                           end else begin
                              drain_in = DrainW'(count_after);
                           end
                           if (count_after != '0) begin
                              out_valid_in = 1'b0;
                              state_in     = ST_DRAIN;
                           end
                        end
                     end
                  end
                  KIND_POWER_ON: begin
                     enabled_in   = 1'b1;
                     manual_in    = 1'b0;
                     angle_in     = low_ff;
                     dir_in       = 1'b1;
                     count_in     = '0;
                     out_valid_in = 1'b1;
                     out_kind_in  = RES_MOVE;
                     out_angle_in = low_ff;
                     out_dist_in  = '0;
                     out_last_in  = 1'b0;
                     state_in     = ST_ONLINE;
                  end
                  KIND_POWER_OFF: begin
                     enabled_in   = 1'b0;
                     out_valid_in = 1'b1;
                     out_kind_in  = RES_STANDBY;
                     out_angle_in = '0;
                     out_dist_in  = '0;
                     out_last_in  = 1'b1;
                  end
                  KIND_MANUAL_ON: begin
                     manual_in = 1'b1;
                  end
                  KIND_MANUAL_OFF: begin
                     manual_in = 1'b0;
                  end
                  KIND_SET_ANGLE: begin
                     if (manual_ff && (req_target_angle >= low_ff) &&
                         (req_target_angle <= high_ff)) begin
                        angle_in     = req_target_angle;
                        out_valid_in = 1'b1;
                        out_kind_in  = RES_MANUAL;
                        out_angle_in = req_target_angle;
                        out_dist_in  = req_distance;
                        out_last_in  = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAIN: begin
            // One stored point a cycle from the head cell, oldest first, while the output is free.
            if (out_free) begin
               chain_ctrl.shift = 1'b1;
               out_valid_in     = 1'b1;
               out_kind_in      = RES_POINT;
               out_angle_in     = chain_head[23:16];
               out_dist_in      = chain_head[15:0];
               out_last_in      = 1'b0;
               drain_in         = drain_ff - DrainW'(1);
               if (drain_ff == DrainW'(1)) begin
                  state_in = ST_MOVE;
               end
            end
         end
         ST_MOVE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = RES_MOVE;
               out_angle_in = angle_ff;
               out_dist_in  = '0;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ONLINE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = RES_ONLINE;
               out_angle_in = '0;
               out_dist_in  = '0;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_SIZE_RESET;
         low_ff       <= LOW_LIMIT_RESET;
         high_ff      <= HIGH_LIMIT_RESET;
         angle_ff     <= ANGLE_RESET;
         dir_ff       <= 1'b1;
         enabled_ff   <= 1'b0;
         manual_ff    <= 1'b0;
         count_ff     <= '0;
         drain_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         angle_ff     <= angle_in;
         dir_ff       <= dir_in;
         enabled_ff   <= enabled_in;
         manual_ff    <= manual_in;
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      out_angle_ff <= out_angle_in;
      out_dist_ff  <= out_dist_in;
      out_last_ff  <= out_last_in;
   end

   ssb_point_chain #(
      .StoreDepth (StoreDepth)
   ) u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .wr_index  (chain_index),
      .wr_data   (chain_wr_data),
      .head_data (chain_head)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_angle_out    = out_angle_ff;
   assign rsp_distance_out = out_dist_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// ----- rtl/ssb_checker.sv -----
// ---------------------------------------------------------------------------
// ssb_checker
// Port-level checks of the sweep scanner, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "servo_sweep_scan_buffer_assert.svh"

module ssb_checker
   import ssb_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [2:0]  req_kind,
   input wire logic [15:0] req_distance,
   input wire logic [7:0]  req_target_angle,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_result_kind,
   input wire logic [7:0]  rsp_angle_out,
   input wire logic [15:0] rsp_distance_out,
   input wire logic        rsp_last,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [1:0]  csr_index,
   input wire logic [7:0]  csr_data
);

   // A stalled result keeps its payload.
   `SSB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) && $stable(rsp_angle_out) && $stable(rsp_distance_out) && $stable(rsp_last), "stalled result changed")

   // No item is taken while a result waits on a stalled receiver.
   `SSB_ASSERT(a_no_take_in_stall, req_valid && req_ready |-> !rsp_valid || rsp_ready, "item taken during output stall")

   // Online, standby and manual results always close their item; a buffered point never does.
   `SSB_ASSERT(a_last_kind, rsp_valid && (rsp_result_kind == RES_ONLINE || rsp_result_kind == RES_STANDBY || rsp_result_kind == RES_MANUAL) |-> rsp_last, "closing result without last")
   `SSB_ASSERT(a_point_not_last, rsp_valid && rsp_result_kind == RES_POINT |-> !rsp_last, "buffered point marked last")

   // Reset empties the output register.
   `SSB_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind servo_sweep_scan_buffer ssb_checker u_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the servo sweep scanner
// A short table of directed items is followed by random phases, each under
// its own step size and limit setting. Every accepted item is run through a
// behavioural sweep model in the bench. Its results, or those of a typed row,
// queue up in order and are compared field by field with each result that
// the block hands over. Both channels idle and stall at random.
// ---------------------------------------------------------------------------

module tb;
   import ssb_pkg::*;

   // Kinds that the block must ignore, and the register index that selects
   // no register.
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;
   localparam logic [1:0] REG_SPARE    = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  angle;
      logic [15:0] range_mm;
      logic        last;
   } sweep_result_type;

   // One row of the directed table; typed rows carry their results by hand.
   typedef struct {
      logic [2:0]       kind;
      logic [15:0]      range_mm;
      logic [7:0]       tgt;
      bit               typed;
      int               n;
      sweep_result_type r0;
      sweep_result_type r1;
   } sweep_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = '0;
   logic [15:0] req_distance = '0;
   logic [7:0]  req_target_angle = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_result_kind;
   logic [7:0]  rsp_angle_out;
   logic [15:0] rsp_distance_out;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   // Model of the sweep: registers, state and the store of points.
   logic [4:0]  cfg_step = STEP_SIZE_RESET;
   logic [7:0]  cfg_lo   = LOW_LIMIT_RESET;
   logic [7:0]  cfg_hi   = HIGH_LIMIT_RESET;
   logic [7:0]  sweep_angle = ANGLE_RESET;
   bit          sweep_up  = 1'b1;
   bit          scan_on   = 1'b0;
   bit          by_hand   = 1'b0;
   logic [23:0] stored_points[$];

   sweep_result_type step_out[$];
   sweep_result_type sweep_due[$];
   sweep_row_type    directed_rows[$];

   bit calm = 1'b0;
   int fault_count = 0;
   int cycle_count = 0;
   int n_items = 0;
   int n_results = 0;
   int n_burst = 0;
   int n_dropped = 0;
   int n_settings = 0;
   int rsp_hold = 0;

   servo_sweep_scan_buffer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_distance     (req_distance),
      .req_target_angle (req_target_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_angle_out    (rsp_angle_out),
      .rsp_distance_out (rsp_distance_out),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #6 clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   function automatic sweep_result_type mk_result(logic [2:0] kind, logic [7:0] angle,
                                                  logic [15:0] range_mm, logic last);
      sweep_result_type r;
      r.kind     = kind;
      r.angle    = angle;
      r.range_mm = range_mm;
      r.last     = last;
      return r;
   endfunction

   // Idle count for one item or result; zero throughout a calm stretch.
   function automatic int idle_draw();
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   // Advance the sweep model by one item and leave its results in step_out.
   function automatic void sweep_predict(logic [2:0] kind, logic [15:0] range_mm,
                                         logic [7:0] tgt);
      int a;
      bit turn;
      sweep_result_type r;
      step_out.delete();
      turn = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (scan_on && !by_hand) begin
               if (stored_points.size() < STORE_DEPTH_DEFAULT)
                  stored_points.insert(stored_points.size(), {sweep_angle, range_mm});
               else
                  n_dropped++;
               a = int'(sweep_angle);
               if (sweep_up) a = a + int'(cfg_step);
               else a = a - int'(cfg_step);
               // The upper limit wins when both are crossed.
               if (a >= int'(cfg_hi)) begin
                  a = int'(cfg_hi);
                  sweep_up = 1'b0;
                  turn = 1'b1;
               end else if (a <= int'(cfg_lo)) begin
                  a = int'(cfg_lo);
                  sweep_up = 1'b1;
                  turn = 1'b1;
               end
               sweep_angle = a[7:0];
               if (turn) begin
                  for (int i = 0; i < stored_points.size() && i < MAX_POINTS; i++) begin
                     step_out.insert(step_out.size(),
                                     mk_result(RES_POINT, stored_points[i][23:16],
                                               stored_points[i][15:0], 1'b0));
                     n_burst++;
                  end
                  stored_points.delete();
               end
               step_out.insert(step_out.size(),
                               mk_result(RES_MOVE, sweep_angle, 16'd0, 1'b0));
            end
         end
         KIND_POWER_ON: begin
            scan_on = 1'b1;
            by_hand = 1'b0;
            sweep_angle = cfg_lo;
            sweep_up = 1'b1;
            stored_points.delete();
            step_out.insert(step_out.size(), mk_result(RES_MOVE, sweep_angle, 16'd0, 1'b0));
            step_out.insert(step_out.size(), mk_result(RES_ONLINE, 8'd0, 16'd0, 1'b0));
         end
         KIND_POWER_OFF: begin
            scan_on = 1'b0;
            step_out.insert(step_out.size(), mk_result(RES_STANDBY, 8'd0, 16'd0, 1'b0));
         end
         KIND_MANUAL_ON: by_hand = 1'b1;
         KIND_MANUAL_OFF: by_hand = 1'b0;
         KIND_SET_ANGLE: begin
            if (by_hand && tgt >= cfg_lo && tgt <= cfg_hi) begin
               sweep_angle = tgt;
               step_out.insert(step_out.size(),
                               mk_result(RES_MANUAL, sweep_angle, range_mm, 1'b0));
            end
         end
         default: ;
      endcase
      if (step_out.size() > 0) begin
         r = step_out.pop_back();
         r.last = 1'b1;
         step_out.insert(step_out.size(), r);
      end
   endfunction

   // Compare every accepted result with the oldest one still due.
   always @(posedge clock) begin : result_check
      sweep_result_type got;
      sweep_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = mk_result(rsp_result_kind, rsp_angle_out, rsp_distance_out, rsp_last);
         n_results++;
         if (sweep_due.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected result: kind %0d angle %0d range %0d last %0d",
                        got.kind, got.angle, got.range_mm, got.last);
            fault_count++;
         end else begin
            want = sweep_due.pop_front();
            if (got.kind !== want.kind || got.angle !== want.angle ||
                got.range_mm !== want.range_mm || got.last !== want.last) begin
               if (fault_count < 10)
                  $display({"mismatch: expected kind %0d angle %0d range %0d last %0d,",
                            " got kind %0d angle %0d range %0d last %0d"},
                           want.kind, want.angle, want.range_mm, want.last,
                           got.kind, got.angle, got.range_mm, got.last);
               fault_count++;
            end
         end
      end
   end

   // Receiver: after each result, hold ready low for a random count.
   always @(posedge clock) begin : result_stall
      int draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            draw = idle_draw();
            if (draw != 0) begin
               rsp_ready <= 1'b0;
               rsp_hold <= draw - 1;
            end
         end
      end else if (rsp_hold == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_hold <= rsp_hold - 1;
      end
   end

   task automatic push_row(logic [2:0] kind, logic [15:0] range_mm, logic [7:0] tgt,
                           bit typed, int n, sweep_result_type r0, sweep_result_type r1);
      sweep_row_type row;
      row.kind     = kind;
      row.range_mm = range_mm;
      row.tgt      = tgt;
      row.typed    = typed;
      row.n        = n;
      row.r0       = r0;
      row.r1       = r1;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Offer one item after a random gap and log what it should cause.
   task automatic drive_item(input sweep_row_type row, output bit live);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= row.kind;
      req_distance     <= row.range_mm;
      req_target_angle <= row.tgt;
      do @(posedge clock); while (!(req_valid && req_ready));
      n_items++;
      sweep_predict(row.kind, row.range_mm, row.tgt);
      if (row.typed) begin
         if (row.n > 0) sweep_due.insert(sweep_due.size(), row.r0);
         if (row.n > 1) sweep_due.insert(sweep_due.size(), row.r1);
      end else begin
         foreach (step_out[i]) sweep_due.insert(sweep_due.size(), step_out[i]);
      end
      live = step_out.size() > 0 || row.kind == KIND_MANUAL_ON ||
             row.kind == KIND_MANUAL_OFF;
   endtask

   // Stop sending until every due result has arrived and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (sweep_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         REG_STEP_SIZE:  cfg_step = data[4:0];
         REG_LOW_LIMIT:  cfg_lo = data;
         REG_HIGH_LIMIT: cfg_hi = data;
         default: ;
      endcase
   endtask

   // One random phase under a fresh setting; tick_pct sets how often ticks come.
   task automatic run_phase(logic [4:0] step, logic [7:0] lo, logic [7:0] hi,
                            int n_live, int tick_pct, bit spare_write);
      sweep_row_type row;
      bit live;
      int n_done;
      int pick;
      drain();
      csr_write(REG_STEP_SIZE, {3'b000, step});
      csr_write(REG_LOW_LIMIT, lo);
      csr_write(REG_HIGH_LIMIT, hi);
      if (spare_write) csr_write(REG_SPARE, 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
      n_settings++;
      row.typed = 1'b0;
      row.n = 0;
      row.r0 = '0;
      row.r1 = '0;
      n_done = 0;
      while (n_done < n_live) begin
         if (n_done % 32 == 0) calm = ($urandom_range(0, 3) == 0);
         // Mostly well-formed: get scanning and leave manual mode promptly.
         pick = $urandom_range(0, 99);
         if (!scan_on && pick < 50) row.kind = KIND_POWER_ON;
         else if (by_hand && pick < 40) row.kind = KIND_MANUAL_OFF;
         else if ($urandom_range(0, 99) < tick_pct) row.kind = KIND_TICK;
         else begin
            case ($urandom_range(0, 9))
               0: row.kind = KIND_POWER_ON;
               1: row.kind = KIND_POWER_OFF;
               2, 3: row.kind = KIND_MANUAL_ON;
               4, 5: row.kind = KIND_MANUAL_OFF;
               6, 7, 8: row.kind = KIND_SET_ANGLE;
               default: row.kind = ($urandom_range(0, 1) == 0) ? KIND_SPARE_6 : KIND_SPARE_7;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) row.range_mm = 16'h0000;
         else if (pick < 10) row.range_mm = 16'hFFFF;
         else row.range_mm = 16'($urandom_range(0, 65535));
         if (cfg_lo <= cfg_hi && $urandom_range(0, 9) < 7)
            row.tgt = 8'($urandom_range(cfg_hi, cfg_lo));
         else
            row.tgt = 8'($urandom_range(0, 255));
         drive_item(row, live);
         if (live) n_done++;
         if ($urandom_range(0, 59) == 0) drain();
      end
      calm = 1'b0;
   endtask

   // Main sequence: reset, directed table, random phases, wind-down.
   initial begin : main_seq
      bit live;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table at the reset setting.
      push_row(KIND_TICK, 16'hFFFF, 8'd0, 1, 0, '0, '0);
      push_row(KIND_SET_ANGLE, 16'h1111, 8'd90, 1, 0, '0, '0);
      push_row(KIND_SPARE_6, 16'h0000, 8'hFF, 1, 0, '0, '0);
      push_row(KIND_POWER_ON, 16'hBEEF, 8'd0, 1, 2,
               mk_result(RES_MOVE, 8'd15, 16'd0, 1'b0),
               mk_result(RES_ONLINE, 8'd0, 16'd0, 1'b1));
      push_row(KIND_TICK, 16'hFFFF, 8'hFF, 1, 1,
               mk_result(RES_MOVE, 8'd20, 16'd0, 1'b1), '0);
      push_row(KIND_TICK, 16'h0000, 8'd0, 0, 0, '0, '0);
      push_row(KIND_MANUAL_ON, 16'h0000, 8'd0, 1, 0, '0, '0);
      // A tick in manual mode is ignored.
      push_row(KIND_TICK, 16'h4321, 8'd0, 1, 0, '0, '0);
      push_row(KIND_SET_ANGLE, 16'hABCD, 8'd165, 1, 1,
               mk_result(RES_MANUAL, 8'd165, 16'hABCD, 1'b1), '0);
      push_row(KIND_SET_ANGLE, 16'h0001, 8'd166, 1, 0, '0, '0);
      push_row(KIND_SET_ANGLE, 16'h0000, 8'd15, 1, 1,
               mk_result(RES_MANUAL, 8'd15, 16'h0000, 1'b1), '0);
      push_row(KIND_SET_ANGLE, 16'hFFFF, 8'd14, 1, 0, '0, '0);
      push_row(KIND_SET_ANGLE, 16'hFFFF, 8'd255, 1, 0, '0, '0);
      push_row(KIND_MANUAL_OFF, 16'h0000, 8'd0, 1, 0, '0, '0);
      push_row(KIND_TICK, 16'h1234, 8'd0, 0, 0, '0, '0);
      // Park just below the top, then tick into the upper turn for a burst.
      push_row(KIND_MANUAL_ON, 16'h0000, 8'd0, 1, 0, '0, '0);
      push_row(KIND_SET_ANGLE, 16'h0007, 8'd160, 0, 0, '0, '0);
      push_row(KIND_MANUAL_OFF, 16'h0000, 8'd0, 1, 0, '0, '0);
      push_row(KIND_TICK, 16'h5555, 8'd0, 0, 0, '0, '0);
      push_row(KIND_TICK, 16'hAAAA, 8'd0, 0, 0, '0, '0);
      // Same again at the bottom while sweeping downward.
      push_row(KIND_MANUAL_ON, 16'h0000, 8'd0, 1, 0, '0, '0);
      push_row(KIND_SET_ANGLE, 16'h00FF, 8'd19, 0, 0, '0, '0);
      push_row(KIND_MANUAL_OFF, 16'h0000, 8'd0, 1, 0, '0, '0);
      push_row(KIND_TICK, 16'h00F0, 8'd0, 0, 0, '0, '0);
      push_row(KIND_POWER_OFF, 16'h0000, 8'd0, 1, 1,
               mk_result(RES_STANDBY, 8'd0, 16'd0, 1'b1), '0);
      push_row(KIND_POWER_ON, 16'h0000, 8'd0, 1, 2,
               mk_result(RES_MOVE, 8'd15, 16'd0, 1'b0),
               mk_result(RES_ONLINE, 8'd0, 16'd0, 1'b1));
      push_row(KIND_SPARE_7, 16'hFFFF, 8'hFF, 1, 0, '0, '0);
      foreach (directed_rows[i]) drive_item(directed_rows[i], live);
      n_settings++;

      // Random phases: widest range, fine step that overfills the store,
      // crossed limits, equal limits and a random setting.
      run_phase(5'd30, 8'd0, 8'd180, 60, 80, 1'b0);
      run_phase(5'd1, 8'd60, 8'd120, 120, 97, 1'b0);
      run_phase(5'd17, 8'd170, 8'd10, 40, 70, 1'b0);
      run_phase(5'd12, 8'd100, 8'd100, 30, 70, 1'b0);
      run_phase(5'($urandom_range(1, 30)), 8'($urandom_range(0, 180)),
                8'($urandom_range(0, 180)), 60, 75, 1'b1);

      // Wind down: wait for everything due, then watch for stray results.
      req_valid <= 1'b0;
      while (sweep_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sweep_due.size() != 0) fault_count++;

      $display("run covered %0d items under %0d settings, %0d results checked",
               n_items, n_settings, n_results);
      $display("burst points %0d, points dropped on a full store %0d, faults %0d",
               n_burst, n_dropped, fault_count);
      if (fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
